>>> design/msr_pkg.sv
package msr_pkg;

  // Input word: one event or request from the sensor side.
  typedef struct packed {
    logic [2:0] opcode;
    logic [1:0] sensor_index;
  } in_word_t;

  // Output word: one report.
  typedef struct packed {
    logic [1:0]  result_kind;
    logic [1:0]  sensor_number;
    logic [15:0] value;
  } out_word_t;

  // Raw opcodes on the input channel.
  localparam logic [2:0] OP_TICK  = 3'd0;
  localparam logic [2:0] OP_RISE  = 3'd1;
  localparam logic [2:0] OP_FALL  = 3'd2;
  localparam logic [2:0] OP_QUERY = 3'd3;
  localparam logic [2:0] OP_READ  = 3'd4;

  // Result kinds.
  localparam logic [1:0] KIND_TRIGGER = 2'd0;
  localparam logic [1:0] KIND_STORED  = 2'd1;
  localparam logic [1:0] KIND_REPLY   = 2'd2;
  localparam logic [1:0] KIND_ERROR   = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] REG_SENSOR_COUNT = 2'd0;
  localparam logic [1:0] REG_MIN_WIDTH    = 2'd1;
  localparam logic [1:0] REG_MAX_WIDTH    = 2'd2;
  localparam logic [1:0] REG_TICKS_PER_CM = 2'd3;

  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned WIDTH_W     = 16;
  localparam int unsigned DIVISOR_W   = 8;

  // Reset values of the configuration registers.
  localparam logic [1:0]  RST_SENSOR_COUNT = 2'd0;
  localparam logic [15:0] RST_MIN_WIDTH    = 16'd28;
  localparam logic [15:0] RST_MAX_WIDTH    = 16'd1458;
  localparam logic [7:0]  RST_TICKS_PER_CM = 8'd14;

  // Classified command passed from the front to the back.
  typedef enum logic [2:0] {
    CMD_TICK,
    CMD_RISE,
    CMD_FALL,
    CMD_QUERY,
    CMD_READ
  } cmd_e;

  typedef struct packed {
    cmd_e       op;
    logic [1:0] idx;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  sensor_count;
    logic [15:0] min_width;
    logic [15:0] max_width;
    logic [7:0]  ticks_per_cm;
  } cfg_t;

endpackage

>>> design/msr_front.sv
module msr_front (
  input  logic              in_valid_i,
  input  msr_pkg::in_word_t in_word_i,
  output logic              in_ready_o,
  input  logic              q_full_i,
  output logic              q_push_o,
  output msr_pkg::cmd_t     q_cmd_o
);

  logic known_op;

  // Decode the opcode; drop unknown codes here so they never reach the queue.
  always_comb begin
    known_op   = 1'b1;
    q_cmd_o.op = msr_pkg::CMD_TICK;
    case (in_word_i.opcode)
      msr_pkg::OP_TICK:  q_cmd_o.op = msr_pkg::CMD_TICK;
      msr_pkg::OP_RISE:  q_cmd_o.op = msr_pkg::CMD_RISE;
      msr_pkg::OP_FALL:  q_cmd_o.op = msr_pkg::CMD_FALL;
      msr_pkg::OP_QUERY: q_cmd_o.op = msr_pkg::CMD_QUERY;
      msr_pkg::OP_READ:  q_cmd_o.op = msr_pkg::CMD_READ;
      default:           known_op   = 1'b0;
    endcase
    q_cmd_o.idx = in_word_i.sensor_index;
  end

  assign in_ready_o = !q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i && known_op;

endmodule

>>> design/msr_queue.sv
module msr_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  msr_pkg::cmd_t push_cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          pop_valid_o,
  output msr_pkg::cmd_t pop_cmd_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  msr_pkg::cmd_t entry_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic do_push, do_pop;

  assign full_o      = (cnt_q == CNT_W'(DEPTH));
  assign pop_valid_o = (cnt_q != '0);
  assign pop_cmd_o   = entry_q[rd_ptr_q];
  assign do_push     = push_i && !full_o;
  assign do_pop      = pop_i && pop_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

>>> design/msr_back.sv
module msr_back #(
  parameter int unsigned MAX_SENSORS  = 3,
  parameter int unsigned COUNTER_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  msr_pkg::cfg_t      cfg_i,
  input  logic               cmd_valid_i,
  input  msr_pkg::cmd_t      cmd_i,
  output logic               cmd_pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output msr_pkg::out_word_t out_word_o
);

  localparam int unsigned IDX_W   = (MAX_SENSORS > 1) ? $clog2(MAX_SENSORS) : 1;
  localparam int unsigned CMP_W   = (COUNTER_BITS > msr_pkg::WIDTH_W) ?
                                    COUNTER_BITS : msr_pkg::WIDTH_W;
  localparam int unsigned DSTEP_W = $clog2(msr_pkg::WIDTH_W);
  localparam logic [1:0]  MAX_CLIP = (MAX_SENSORS > 3) ? 2'd3 : 2'(MAX_SENSORS);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_RISE,
    PH_FALL
  } phase_e;

  typedef enum logic [1:0] {
    ST_EXEC,
    ST_DIV,
    ST_REPLY
  } state_e;

  state_e                  st_q, st_d;
  phase_e                  phase_q, phase_d;
  logic [COUNTER_BITS-1:0] cnt_q, cnt_d;
  logic [1:0]              cur_q, cur_d;
  logic [15:0]             width_q [MAX_SENSORS];
  logic                    wr_en;
  logic [IDX_W-1:0]        wr_idx;
  logic [15:0]             wr_width;

  logic                        out_valid_q, out_valid_d;
  msr_pkg::out_word_t          out_word_q, out_word_d;

  // Serial divider: one quotient bit per cycle.
  logic [msr_pkg::WIDTH_W-1:0]   quo_q, quo_d;
  logic [msr_pkg::DIVISOR_W-1:0] rem_q, rem_d;
  logic [msr_pkg::DIVISOR_W-1:0] dvs_q, dvs_d;
  logic [DSTEP_W-1:0]            step_q, step_d;
  logic [1:0]                    rd_idx_q, rd_idx_d;
  logic [msr_pkg::DIVISOR_W:0]   rem_sh;
  logic                          q_bit;

  logic [1:0]       count;
  logic [1:0]       cur_eff;
  logic [2:0]       cur_nxt;
  logic [CMP_W-1:0] cnt_ext;
  logic             in_window;
  logic [15:0]      meas;
  logic             out_free;

  assign count    = (cfg_i.sensor_count < MAX_CLIP) ? cfg_i.sensor_count : MAX_CLIP;
  assign cur_eff  = (cur_q >= count) ? 2'd0 : cur_q;
  assign cur_nxt  = {1'b0, cur_eff} + 3'd1;
  assign cnt_ext  = CMP_W'(cnt_q);
  assign in_window = !(cnt_ext > CMP_W'(cfg_i.max_width) ||
                       cnt_ext < CMP_W'(cfg_i.min_width));
  assign meas     = in_window ? cnt_ext[15:0] : 16'd0;
  assign out_free = !out_valid_q || out_ready_i;

  // A zero divisor gives all ones, which is the saturated reply.
  assign rem_sh = {rem_q, quo_q[msr_pkg::WIDTH_W-1]};
  assign q_bit  = (rem_sh >= {1'b0, dvs_q});

  assign cmd_pop_o   = (st_q == ST_EXEC) && cmd_valid_i && out_free;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  always_comb begin
    st_d        = st_q;
    phase_d     = phase_q;
    cnt_d       = cnt_q;
    cur_d       = cur_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_word_d  = out_word_q;
    quo_d       = quo_q;
    rem_d       = rem_q;
    dvs_d       = dvs_q;
    step_d      = step_q;
    rd_idx_d    = rd_idx_q;
    wr_en       = 1'b0;
    wr_idx      = IDX_W'(cur_eff);
    wr_width    = meas;

    case (st_q)
      ST_EXEC: begin
        if (cmd_pop_o) begin
          case (cmd_i.op)
            msr_pkg::CMD_TICK: begin
              if (phase_q != PH_IDLE && cnt_q != '1) begin
                cnt_d = cnt_q + 1'b1;
              end
            end
            msr_pkg::CMD_RISE: begin
              if (phase_q == PH_RISE) begin
                cnt_d   = '0;
                phase_d = PH_FALL;
              end
            end
            msr_pkg::CMD_FALL: begin
              if (phase_q == PH_FALL) begin
                out_valid_d = 1'b1;
                out_word_d  = '{result_kind: msr_pkg::KIND_STORED,
                                sensor_number: cur_eff, value: meas};
                if (count != 2'd0) begin
                  wr_en = 1'b1;
                  cur_d = (cur_nxt >= {1'b0, count}) ? 2'd0 : cur_nxt[1:0];
                end else begin
                  cur_d = 2'd0;
                end
                cnt_d   = '0;
                phase_d = PH_IDLE;
              end
            end
            msr_pkg::CMD_QUERY: begin
              if (count != 2'd0 && phase_q == PH_IDLE) begin
                cur_d       = cur_eff;
                out_valid_d = 1'b1;
                out_word_d  = '{result_kind: msr_pkg::KIND_TRIGGER,
                                sensor_number: cur_eff, value: 16'd0};
                cnt_d       = '0;
                phase_d     = PH_RISE;
              end
            end
            msr_pkg::CMD_READ: begin
              if (cmd_i.idx >= count) begin
                out_valid_d = 1'b1;
                out_word_d  = '{result_kind: msr_pkg::KIND_ERROR,
                                sensor_number: cmd_i.idx, value: 16'd0};
              end else begin
                quo_d    = width_q[IDX_W'(cmd_i.idx)];
                rem_d    = '0;
                dvs_d    = cfg_i.ticks_per_cm;
                step_d   = '0;
                rd_idx_d = cmd_i.idx;
                st_d     = ST_DIV;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_DIV: begin
        rem_d  = q_bit ? msr_pkg::DIVISOR_W'(rem_sh - {1'b0, dvs_q})
                       : rem_sh[msr_pkg::DIVISOR_W-1:0];
        quo_d  = {quo_q[msr_pkg::WIDTH_W-2:0], q_bit};
        step_d = step_q + 1'b1;
        if (step_q == DSTEP_W'(msr_pkg::WIDTH_W - 1)) begin
          st_d = ST_REPLY;
        end
      end
      ST_REPLY: begin
        // Hold the quotient until the output register frees up.
        if (out_free) begin
          out_valid_d = 1'b1;
          out_word_d  = '{result_kind: msr_pkg::KIND_REPLY,
                          sensor_number: rd_idx_q, value: quo_q};
          st_d        = ST_EXEC;
        end
      end
      default: begin
        st_d = ST_EXEC;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_EXEC;
      phase_q     <= PH_IDLE;
      cnt_q       <= '0;
      cur_q       <= 2'd0;
      out_valid_q <= 1'b0;
      out_word_q  <= '0;
      quo_q       <= '0;
      rem_q       <= '0;
      dvs_q       <= '0;
      step_q      <= '0;
      rd_idx_q    <= 2'd0;
      for (int i = 0; i < int'(MAX_SENSORS); i++) begin
        width_q[i] <= 16'd0;
      end
    end else begin
      st_q        <= st_d;
      phase_q     <= phase_d;
      cnt_q       <= cnt_d;
      cur_q       <= cur_d;
      out_valid_q <= out_valid_d;
      out_word_q  <= out_word_d;
      quo_q       <= quo_d;
      rem_q       <= rem_d;
      dvs_q       <= dvs_d;
      step_q      <= step_d;
      rd_idx_q    <= rd_idx_d;
      if (wr_en) begin
        width_q[wr_idx] <= wr_width;
      end
    end
  end

endmodule

>>> design/multi_sonar_echo_ranger_unit.sv
// Round-robin controller for up to MAX_SENSORS (at most 3) ultrasonic echo rangers.
// Input channel (in_valid_i/in_ready_o, in_word_i): each word is a
// prescaled tick, a rising or falling echo edge, a query or a distance
// read. Output channel (out_valid_o/out_ready_i, out_word_o): at most one
// word per input word - trigger sent, measurement stored, distance reply
// or read error. Unknown opcodes and events that do not fit the current
// phase give no output word.
// A decoded word waits in a two-entry queue; an event or query loads the
// output register when the back end pops it. A distance read runs a
// bit-serial divider, one quotient bit per cycle, and then loads the
// output register; the back end takes no new word while it divides.
// Other words retire at one per cycle while the output register is free
// and no divide runs.
// Reset clears the phase, tick counter, sensor pointer and stored widths
// to zero and loads the configuration defaults (0 sensors, window 28 to
// 1458 ticks, 14 ticks per cm). When the receiver stalls, the output word
// holds, the back end stops draining, and the queue keeps taking words
// until full. Configuration writes (cfg_we_i) take effect at once and
// are meant to happen only while the block is idle.
module multi_sonar_echo_ranger_unit #(
  parameter int unsigned MAX_SENSORS  = 3,
  parameter int unsigned COUNTER_BITS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  msr_pkg::in_word_t               in_word_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output msr_pkg::out_word_t              out_word_o,
  input  logic                            cfg_we_i,
  input  logic [1:0]                      cfg_index_i,
  input  logic [msr_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  msr_pkg::cfg_t cfg_q;
  msr_pkg::cmd_t push_cmd, pop_cmd;
  logic          q_full, q_push, q_pop, q_valid;

  // Configuration registers: plain write, no read-back.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sensor_count <= msr_pkg::RST_SENSOR_COUNT;
      cfg_q.min_width    <= msr_pkg::RST_MIN_WIDTH;
      cfg_q.max_width    <= msr_pkg::RST_MAX_WIDTH;
      cfg_q.ticks_per_cm <= msr_pkg::RST_TICKS_PER_CM;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        msr_pkg::REG_SENSOR_COUNT: cfg_q.sensor_count <= cfg_data_i[1:0];
        msr_pkg::REG_MIN_WIDTH:    cfg_q.min_width    <= cfg_data_i;
        msr_pkg::REG_MAX_WIDTH:    cfg_q.max_width    <= cfg_data_i;
        msr_pkg::REG_TICKS_PER_CM: cfg_q.ticks_per_cm <= cfg_data_i[7:0];
        default: begin
        end
      endcase
    end
  end

  // Front: accept and classify each input word; drop unknown opcodes.
  msr_front u_front (
    .in_valid_i (in_valid_i),
    .in_word_i  (in_word_i),
    .in_ready_o (in_ready_o),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_cmd_o    (push_cmd)
  );

  // Queue: decouple the front from a stalled or dividing back end.
  msr_queue #(
    .DEPTH (msr_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_cmd_i  (push_cmd),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .pop_valid_o (q_valid),
    .pop_cmd_o   (pop_cmd)
  );

  // Back: ranging state machine, width store, serial divider, output reg.
  msr_back #(
    .MAX_SENSORS  (MAX_SENSORS),
    .COUNTER_BITS (COUNTER_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_valid_i (q_valid),
    .cmd_i       (pop_cmd),
    .cmd_pop_o   (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

endmodule

>>> dv/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // Sensors the instance serves; matches the default of the unit.
  localparam int unsigned SENSORS       = 3;
  // Watchdog limit for the whole run.
  localparam int unsigned CYCLE_LIMIT   = 200_000;
  // Quiet time after the last report: covers a divide plus queued words
  // that give no report (ticks, ignored edges).
  localparam int unsigned SETTLE_CYCLES = 40;
  // Words sent per idle mix of the random part.
  localparam int unsigned RANDOM_WORDS  = 520;
  localparam logic [15:0] TICK_TOP      = 16'hFFFF;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_WAIT_RISE,
    PH_WAIT_FALL
  } echo_phase_e;

  // Clock, reset and the unit's ports.
  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_ready_o;
  msr_pkg::in_word_t  in_word_i   = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  msr_pkg::out_word_t out_word_o;
  logic               cfg_we_i    = 1'b0;
  logic [1:0]         cfg_index_i = '0;
  logic [msr_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;

  // Mirror of the ranger: configuration and measurement state.
  logic [1:0]  cfg_sensors = msr_pkg::RST_SENSOR_COUNT;
  logic [15:0] cfg_min_w   = msr_pkg::RST_MIN_WIDTH;
  logic [15:0] cfg_max_w   = msr_pkg::RST_MAX_WIDTH;
  logic [7:0]  cfg_tpc     = msr_pkg::RST_TICKS_PER_CM;
  echo_phase_e echo_phase  = PH_IDLE;
  logic [15:0] echo_ticks  = '0;
  logic [1:0]  next_sensor = '0;
  logic [15:0] width_mem [SENSORS] = '{default: '0};

  // Reports still owed by the unit, oldest first.
  msr_pkg::out_word_t pending_reports [$];
  msr_pkg::out_word_t want_word;

  int unsigned error_count    = 0;
  int unsigned sent_words     = 0;
  int unsigned cycle_count    = 0;
  int unsigned send_gap_pct   = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_cycles    = 0;

  multi_sonar_echo_ranger_unit #(
    .MAX_SENSORS (SENSORS),
    .COUNTER_BITS(16)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_word_o (out_word_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Watchdog: abort a hung run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: watchdog expired after %0d cycles", $time, cycle_count);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Receiver: a requested hold-off wins; otherwise stall at the current rate.
  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      out_ready_i <= 1'b0;
      hold_cycles--;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Compare every accepted report word with the oldest one owed.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_reports.size() == 0) begin
        $display("%0t: report word with none expected: kind %0d sensor %0d value %0d",
                 $time, out_word_o.result_kind, out_word_o.sensor_number,
                 out_word_o.value);
        error_count++;
      end else begin
        want_word = pending_reports.pop_front();
        if (out_word_o.result_kind !== want_word.result_kind) begin
          $display("%0t: result_kind mismatch: expected %0d, actual %0d", $time,
                   want_word.result_kind, out_word_o.result_kind);
          error_count++;
        end
        if (out_word_o.sensor_number !== want_word.sensor_number) begin
          $display("%0t: sensor_number mismatch: expected %0d, actual %0d", $time,
                   want_word.sensor_number, out_word_o.sensor_number);
          error_count++;
        end
        if (out_word_o.value !== want_word.value) begin
          $display("%0t: value mismatch: expected %0d, actual %0d", $time,
                   want_word.value, out_word_o.value);
          error_count++;
        end
      end
    end
  end

  // Advance the mirror by one accepted input word and queue the report it
  // owes, if any.
  function automatic void ranger_predict(msr_pkg::in_word_t w);
    msr_pkg::out_word_t rep;
    logic [15:0]        width;
    rep = '0;
    case (w.opcode)
      msr_pkg::OP_TICK: begin
        // The counter only runs while a measurement is in flight.
        if (echo_phase != PH_IDLE) begin
          if (echo_ticks != TICK_TOP) echo_ticks = echo_ticks + 16'd1;
        end
      end
      msr_pkg::OP_RISE: begin
        if (echo_phase == PH_WAIT_RISE) begin
          echo_ticks = '0;
          echo_phase = PH_WAIT_FALL;
        end
      end
      msr_pkg::OP_FALL: begin
        if (echo_phase == PH_WAIT_FALL) begin
          // A pointer left past a lowered count falls back to sensor 0.
          if (next_sensor >= cfg_sensors) next_sensor = '0;
          width = echo_ticks;
          if (width > cfg_max_w || width < cfg_min_w) width = '0;
          rep.result_kind   = msr_pkg::KIND_STORED;
          rep.sensor_number = next_sensor;
          rep.value         = width;
          pending_reports.push_back(rep);
          if (cfg_sensors != 2'd0 && next_sensor < SENSORS) begin
            width_mem[next_sensor] = width;
            next_sensor = next_sensor + 2'd1;
            if (next_sensor >= cfg_sensors) next_sensor = '0;
          end else begin
            next_sensor = '0;
          end
          echo_ticks = '0;
          echo_phase = PH_IDLE;
        end
      end
      msr_pkg::OP_QUERY: begin
        if (cfg_sensors != 2'd0 && echo_phase == PH_IDLE) begin
          if (next_sensor >= cfg_sensors) next_sensor = '0;
          rep.result_kind   = msr_pkg::KIND_TRIGGER;
          rep.sensor_number = next_sensor;
          pending_reports.push_back(rep);
          echo_ticks = '0;
          echo_phase = PH_WAIT_RISE;
        end
      end
      msr_pkg::OP_READ: begin
        rep.sensor_number = w.sensor_index;
        if (w.sensor_index >= cfg_sensors || w.sensor_index >= SENSORS) begin
          rep.result_kind = msr_pkg::KIND_ERROR;
        end else if (cfg_tpc == 8'd0) begin
          rep.result_kind = msr_pkg::KIND_REPLY;
          rep.value       = 16'hFFFF;
        end else begin
          rep.result_kind = msr_pkg::KIND_REPLY;
          rep.value       = width_mem[w.sensor_index] / {8'd0, cfg_tpc};
        end
        pending_reports.push_back(rep);
      end
      default: ;
    endcase
  endfunction

  // Offer one word, hold it until accepted, then idle at the current rate.
  // Enter and leave at a falling edge.
  task automatic send_word(input logic [2:0] op, input logic [1:0] idx);
    msr_pkg::in_word_t w;
    w.opcode       = op;
    w.sensor_index = idx;
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    ranger_predict(w);
    sent_words++;
    @(negedge clk_i);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
  endtask

  // Drop valid, wait for every owed report, then let queued silent words retire.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending_reports.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // One register write; only called with the unit idle.
  task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    case (idx)
      msr_pkg::REG_SENSOR_COUNT: cfg_sensors = data[1:0];
      msr_pkg::REG_MIN_WIDTH:    cfg_min_w   = data;
      msr_pkg::REG_MAX_WIDTH:    cfg_max_w   = data;
      msr_pkg::REG_TICKS_PER_CM: cfg_tpc     = data[7:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // Full measurement: query, rising edge, n ticks, falling edge.
  task automatic measure(input int unsigned n_ticks);
    send_word(msr_pkg::OP_QUERY, 2'd0);
    send_word(msr_pkg::OP_RISE, 2'd0);
    repeat (n_ticks) send_word(msr_pkg::OP_TICK, 2'd0);
    send_word(msr_pkg::OP_FALL, 2'd0);
  endtask

  // Out of reset there are no sensors: reads fail, queries and edges drop.
  task automatic test_power_on();
    send_word(msr_pkg::OP_READ, 2'd0);
    send_word(msr_pkg::OP_READ, 2'd3);
    send_word(msr_pkg::OP_QUERY, 2'd0);
    send_word(msr_pkg::OP_TICK, 2'd1);
    send_word(msr_pkg::OP_RISE, 2'd2);
    send_word(msr_pkg::OP_FALL, 2'd3);
    send_word(3'd5, 2'd1);
    send_word(3'd6, 2'd2);
    send_word(3'd7, 2'd3);
    wait_idle();
  endtask

  // Widths on and just past both window limits, plus edges in the wrong phase.
  task automatic test_window_edges();
    write_reg(msr_pkg::REG_SENSOR_COUNT, 16'd3);
    write_reg(msr_pkg::REG_MIN_WIDTH, 16'd1);
    write_reg(msr_pkg::REG_MAX_WIDTH, 16'd2);
    write_reg(msr_pkg::REG_TICKS_PER_CM, 16'd1);
    send_word(msr_pkg::OP_QUERY, 2'd0);
    send_word(msr_pkg::OP_QUERY, 2'd1);   // busy: drop
    send_word(msr_pkg::OP_FALL, 2'd0);    // still waiting for the rising edge
    send_word(msr_pkg::OP_TICK, 2'd0);    // counts, then cleared by the edge
    send_word(msr_pkg::OP_RISE, 2'd0);
    send_word(msr_pkg::OP_RISE, 2'd0);    // second rising edge: drop
    send_word(msr_pkg::OP_TICK, 2'd0);
    send_word(msr_pkg::OP_TICK, 2'd0);
    send_word(msr_pkg::OP_FALL, 2'd0);    // width at the upper limit
    measure(3);                           // just above: stored as zero
    measure(1);                           // at the lower limit
    measure(0);                           // below it
    send_word(msr_pkg::OP_READ, 2'd0);
    send_word(msr_pkg::OP_READ, 2'd1);
    send_word(msr_pkg::OP_READ, 2'd2);
    send_word(msr_pkg::OP_READ, 2'd3);    // beyond the attached sensors
    wait_idle();
  endtask

  // Lower the count under the round-robin pointer, before a query and
  // in the middle of a measurement.
  task automatic test_stale_pointer();
    measure(1);
    wait_idle();
    write_reg(msr_pkg::REG_SENSOR_COUNT, 16'd1);
    measure(2);
    wait_idle();
    write_reg(msr_pkg::REG_SENSOR_COUNT, 16'd3);
    measure(1);
    measure(2);
    send_word(msr_pkg::OP_QUERY, 2'd0);
    send_word(msr_pkg::OP_RISE, 2'd0);
    send_word(msr_pkg::OP_TICK, 2'd0);
    wait_idle();
    write_reg(msr_pkg::REG_SENSOR_COUNT, 16'd0);
    send_word(msr_pkg::OP_FALL, 2'd0);    // reported, but nothing is stored
    send_word(msr_pkg::OP_READ, 2'd0);
    wait_idle();
    write_reg(msr_pkg::REG_SENSOR_COUNT, 16'd2);
    measure(2);
    send_word(msr_pkg::OP_READ, 2'd2);
    wait_idle();
  endtask

  // Store a long width through a one-value window, then read it through
  // the divisor extremes, zero included.
  task automatic test_divider_extremes();
    int unsigned saved_gap;
    saved_gap = send_gap_pct;
    wait_idle();
    write_reg(msr_pkg::REG_SENSOR_COUNT, 16'd1);
    write_reg(msr_pkg::REG_MIN_WIDTH, 16'd250);
    write_reg(msr_pkg::REG_MAX_WIDTH, 16'd250);
    write_reg(msr_pkg::REG_TICKS_PER_CM, 16'd1);
    send_gap_pct = 0;
    measure(250);
    send_gap_pct = saved_gap;
    send_word(msr_pkg::OP_READ, 2'd0);
    wait_idle();
    write_reg(msr_pkg::REG_TICKS_PER_CM, 16'd255);
    send_word(msr_pkg::OP_READ, 2'd0);
    wait_idle();
    write_reg(msr_pkg::REG_TICKS_PER_CM, 16'd0);
    send_word(msr_pkg::OP_READ, 2'd0);
    send_word(msr_pkg::OP_READ, 2'd1);
    wait_idle();
  endtask

  // Hold the receiver off long enough that the queue fills and input ready
  // drops, keep offering words, then pause the sender until all drain.
  task automatic test_backpressure();
    int unsigned saved_gap;
    saved_gap = send_gap_pct;
    write_reg(msr_pkg::REG_SENSOR_COUNT, 16'd3);
    write_reg(msr_pkg::REG_MIN_WIDTH, 16'd0);
    write_reg(msr_pkg::REG_MAX_WIDTH, 16'd10);
    write_reg(msr_pkg::REG_TICKS_PER_CM, 16'd3);
    @(posedge clk_i);
    hold_cycles = 300;
    @(negedge clk_i);
    send_gap_pct = 0;
    repeat (4) begin
      measure($urandom_range(0, 12));
      send_word(msr_pkg::OP_READ, 2'($urandom_range(3)));
      send_word(msr_pkg::OP_READ, 2'($urandom_range(3)));
    end
    send_gap_pct = saved_gap;
    wait_idle();
  endtask

  // New random settings; extremes now and then. Upper data bits of the
  // narrow registers carry junk that must be ignored.
  task automatic random_setup();
    logic [1:0]  cnt;
    logic [15:0] lo;
    logic [15:0] hi;
    logic [7:0]  tpc;
    cnt = ($urandom_range(9) == 0) ? 2'd0 : 2'($urandom_range(1, 3));
    lo  = 16'($urandom_range(0, 8));
    case ($urandom_range(9))
      0:       hi = 16'd0;
      1:       hi = 16'hFFFF;
      2:       hi = 16'($urandom_range(0, 8));
      default: hi = lo + 16'($urandom_range(0, 16));
    endcase
    case ($urandom_range(9))
      0:       tpc = 8'd0;
      1:       tpc = 8'd255;
      default: tpc = 8'($urandom_range(1, 6));
    endcase
    write_reg(msr_pkg::REG_SENSOR_COUNT, {14'($urandom_range(0, 16383)), cnt});
    write_reg(msr_pkg::REG_MIN_WIDTH, lo);
    write_reg(msr_pkg::REG_MAX_WIDTH, hi);
    write_reg(msr_pkg::REG_TICKS_PER_CM, {8'($urandom_range(0, 255)), tpc});
  endtask

  // Well-formed measurement with random content and stray words inside.
  task automatic random_measure();
    int unsigned n_ticks;
    n_ticks = $urandom_range(0, 24);
    send_word(msr_pkg::OP_QUERY, 2'($urandom_range(3)));
    if ($urandom_range(9) == 0) send_word(msr_pkg::OP_TICK, 2'($urandom_range(3)));
    send_word(msr_pkg::OP_RISE, 2'($urandom_range(3)));
    repeat (n_ticks) begin
      if ($urandom_range(15) == 0) send_word(msr_pkg::OP_READ, 2'($urandom_range(3)));
      send_word(msr_pkg::OP_TICK, 2'($urandom_range(3)));
    end
    send_word(msr_pkg::OP_FALL, 2'($urandom_range(3)));
    if ($urandom_range(2) == 0) send_word(msr_pkg::OP_READ, 2'($urandom_range(3)));
  endtask

  // Random traffic under one idle mix, with settings changed between groups.
  task automatic test_random_mix(input int unsigned gap_pct, input int unsigned stall_pct);
    int unsigned start_words;
    int unsigned group_start;
    send_gap_pct   = gap_pct;
    recv_stall_pct = stall_pct;
    start_words    = sent_words;
    group_start    = sent_words;
    wait_idle();
    random_setup();
    while (sent_words - start_words < RANDOM_WORDS) begin
      if (sent_words - group_start >= 60) begin
        wait_idle();
        random_setup();
        group_start = sent_words;
      end
      if ($urandom_range(99) < 80) begin
        random_measure();
      end else begin
        // Noise: any opcode, unknown ones too, which also breaks sequences.
        repeat ($urandom_range(1, 4))
          send_word(3'($urandom_range(7)), 2'($urandom_range(3)));
      end
    end
    wait_idle();
  endtask

  initial begin
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    send_gap_pct   = 18;
    recv_stall_pct = 67;
    test_power_on();
    test_window_edges();
    test_stale_pointer();
    test_divider_extremes();
    test_backpressure();
    test_random_mix(18, 67);
    test_random_mix(67, 18);
    test_random_mix(0, 0);
    wait_idle();
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> multi_sonar_echo_ranger_unit.f
design/msr_pkg.sv
design/msr_front.sv
design/msr_queue.sv
design/msr_back.sv
design/multi_sonar_echo_ranger_unit.sv
dv/tb_top.sv
